// ===== hw/rtl/pbem_pkg.sv =====
// ----------------------------------------------------------------------------
// pbem_pkg
// Types and constants shared by the protected big-endian memory block.
// ----------------------------------------------------------------------------
package pbem_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    localparam logic [2:0] USER_FC_MAX      = 3'd2;
    localparam int         LOW_VECTOR_LIMIT = 1024;

    localparam logic       REG_REGION_SIZE = 1'b0;
    localparam logic       REG_PROTECT     = 1'b1;

    localparam logic [16:0] REGION_SIZE_RESET = 17'h10000;
    localparam logic        PROTECT_RESET     = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [2:0]  function_code;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic            ok;
        logic            wr;
        logic [3:0]      en;
        logic [3:0]      carry;
        logic [3:0][7:0] wbyte;
    } lane_ctl_t;

endpackage

// ===== hw/rtl/pbem_check.sv =====
// ----------------------------------------------------------------------------
// pbem_check
// Bounds and protection check, and byte lane steering for one access.
// ----------------------------------------------------------------------------
module pbem_check #(
    parameter int MEM_BYTES = 65536
) (
    input  pbem_pkg::in_item_t  item,
    input  logic [16:0]         region_size,
    input  logic                protect_low_vectors,
    output pbem_pkg::lane_ctl_t ctl
);

    localparam logic [24:0] MEM_LIMIT = 25'(MEM_BYTES);

    logic [24:0] limit;
    logic [33:0] end_addr;
    logic [2:0]  len;
    logic [1:0]  lenm1;
    logic        size_ok;
    logic        cmd_ok;
    logic        prot_fault;
    logic        bound_fault;
    logic [1:0]  a0;

    always_comb
    begin
        size_ok = 1'b1;
        len     = 3'd1;
        lenm1   = 2'd0;
        unique case (item.access_size)
            pbem_pkg::SIZE_BYTE:
            begin
                len   = 3'd1;
                lenm1 = 2'd0;
            end
            pbem_pkg::SIZE_WORD:
            begin
                len   = 3'd2;
                lenm1 = 2'd1;
            end
            pbem_pkg::SIZE_LONG:
            begin
                len   = 3'd4;
                lenm1 = 2'd3;
            end
            default:
            begin
                size_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        limit       = (25'(region_size) > MEM_LIMIT) ? MEM_LIMIT : 25'(region_size);
        end_addr    = {2'b00, item.address} + 34'(len);
        cmd_ok      = (item.command == pbem_pkg::CMD_READ)
                   || (item.command == pbem_pkg::CMD_WRITE)
                   || (item.command == pbem_pkg::CMD_FETCH);
        prot_fault  = protect_low_vectors
                   && (item.address < 32'(pbem_pkg::LOW_VECTOR_LIMIT))
                   && ((item.function_code <= pbem_pkg::USER_FC_MAX)
                       || (item.command == pbem_pkg::CMD_FETCH));
        bound_fault = end_addr > 34'(limit);
        a0          = item.address[1:0];
    end

    always_comb
    begin
        logic [1:0] k;
        logic [1:0] idx;
        ctl.ok = size_ok && cmd_ok && !prot_fault && !bound_fault;
        ctl.wr = item.command == pbem_pkg::CMD_WRITE;
        for (int b = 0; b < 4; b++)
        begin
            k   = 2'(b) - a0;
            idx = lenm1 - k;
            ctl.en[b]    = k <= lenm1;
            ctl.carry[b] = 2'(b) < a0;
            ctl.wbyte[b] = item.write_data[8*idx +: 8];
        end
    end

endmodule

// ===== hw/rtl/pbem_bank.sv =====
// ----------------------------------------------------------------------------
// pbem_bank
// One byte-wide bank of the memory, synchronous read with a registered output.
// ----------------------------------------------------------------------------
module pbem_bank #(
    parameter int ROWS = 16384,
    parameter int RW   = 14
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [RW-1:0] row,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[row] <= wdata;
            end
            rdata_reg <= mem[row];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/protected_big_endian_memory.sv =====
// ----------------------------------------------------------------------------
// protected_big_endian_memory
// Big-endian byte-addressed RAM with bounds and low-vector protection.
//
//   channel   signals                          handshake
//   request   request (in_item_t)              start & !busy
//   result    result (out_item_t)              result_valid, one cycle
//   config    psel penable pwrite paddr pwdata  apb, pready tied high
//
// one item per cycle; each result passes the bank output and s1 registers, then the result register
// four byte banks, each with one port, serve any alignment in one access
// busy stays low; a write is in memory before the next item reads
// memory contents are undefined after reset, registers take reset values
// ----------------------------------------------------------------------------
module protected_big_endian_memory #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pbem_pkg::in_item_t   request,
    output logic                 result_valid,
    output pbem_pkg::out_item_t  result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int RW   = $clog2(ROWS);

    logic [16:0] region_size_reg;
    logic        protect_reg;

    pbem_pkg::lane_ctl_t ctl;
    logic                accept;
    logic [RW-1:0]       row0;
    logic [3:0][7:0]     bank_rdata;

    logic       s1_valid_reg;
    logic       s1_ok_reg;
    logic       s1_read_reg;
    logic [1:0] s1_a0_reg;
    logic [1:0] s1_size_reg;

    logic                result_valid_reg;
    pbem_pkg::out_item_t result_reg;
    pbem_pkg::out_item_t result_next;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= pbem_pkg::REGION_SIZE_RESET;
            protect_reg     <= pbem_pkg::PROTECT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                pbem_pkg::REG_REGION_SIZE: region_size_reg <= pwdata[16:0];
                pbem_pkg::REG_PROTECT:     protect_reg     <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    assign prdata = (paddr[2] == pbem_pkg::REG_REGION_SIZE) ? 32'(region_size_reg)
                                                           : 32'(protect_reg);

    pbem_check #(
        .MEM_BYTES (MEM_BYTES)
    ) u_check (
        .item                (request),
        .region_size         (region_size_reg),
        .protect_low_vectors (protect_reg),
        .ctl                 (ctl)
    );

    assign row0 = request.address[RW+1:2];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        pbem_bank #(
            .ROWS (ROWS),
            .RW   (RW)
        ) u_bank (
            .clk   (clk),
            .en    (accept && ctl.ok && ctl.en[b]),
            .we    (ctl.wr),
            .row   (row0 + RW'(ctl.carry[b])),
            .wdata (ctl.wbyte[b]),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept;
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg   <= ctl.ok;
            s1_read_reg <= ctl.ok && !ctl.wr;
            s1_a0_reg   <= request.address[1:0];
            s1_size_reg <= request.access_size;
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        logic [3:0][7:0] r;
        logic [31:0]     value;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = bank_rdata[s1_a0_reg + 2'(i)];
        end
        unique case (s1_size_reg)
            pbem_pkg::SIZE_BYTE: value = {24'd0, r[0]};
            pbem_pkg::SIZE_WORD: value = {16'd0, r[0], r[1]};
            pbem_pkg::SIZE_LONG: value = {r[0], r[1], r[2], r[3]};
            default:             value = 32'd0;
        endcase
        result_next.ok        = s1_ok_reg;
        result_next.read_data = s1_read_reg ? value : 32'd0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== tb/sv/pbem_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbem_result_checker
// Watches the request, result and register channels of the protected
// big-endian memory. Keeps its own byte image and register copies, works
// out the expected result of every accepted access and compares each result
// field by field, in order. Mismatches and outstanding results go to the top.
// ----------------------------------------------------------------------------
module pbem_result_checker
    import pbem_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    request,
    input  logic        result_valid,
    input  out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);

    logic [7:0]  ram_image [MEM_BYTES];
    logic [16:0] region_q;
    logic        protect_q;
    out_item_t   expected_results [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h expected %h at %0t ns", what, got, want, $time);
        mismatches++;
    endtask

    function automatic int unsigned byte_count(logic [1:0] size);
        case (size)
            SIZE_BYTE: return 1;
            SIZE_WORD: return 2;
            SIZE_LONG: return 4;
            default:   return 0;
        endcase
    endfunction

    function automatic out_item_t predict_access(in_item_t it);
        out_item_t       res;
        int unsigned     len;
        longint unsigned limit;
        logic [31:0]     value;
        logic [31:0]     data;
        res   = '0;
        value = '0;
        data  = it.write_data;
        len   = byte_count(it.access_size);
        limit = (region_q > MEM_BYTES) ? MEM_BYTES : region_q;
        if (len == 0 || (it.command != CMD_READ && it.command != CMD_WRITE
                         && it.command != CMD_FETCH))
            return res;
        // low vectors: user space or any fetch
        if (protect_q && it.address < LOW_VECTOR_LIMIT
            && (it.function_code <= USER_FC_MAX || it.command == CMD_FETCH))
            return res;
        if ({32'd0, it.address} + len > limit)
            return res;
        for (int i = 0; i < len; i++)
        begin
            if (it.command == CMD_WRITE)
                ram_image[it.address + i] = data[8 * (len - 1 - i) +: 8];
            else
                value = {value[23:0], ram_image[it.address + i]};
        end
        res.ok        = 1'b1;
        res.read_data = value;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            region_q  <= REGION_SIZE_RESET;
            protect_q <= PROTECT_RESET;
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_PROTECT)
                    protect_q <= pwdata[0];
                else
                    region_q <= pwdata[16:0];
            end
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with none expected", result.read_data, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.ok !== want.ok)
                        report_mismatch("ok", {31'd0, result.ok}, {31'd0, want.ok});
                    if (result.read_data !== want.read_data)
                        report_mismatch("read_data", result.read_data, want.read_data);
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_access(request));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/protected_big_endian_memory_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protected_big_endian_memory_tb
// Drives accesses and register writes into the protected big-endian memory.
// A directed run covers alignment at the region edge, wrap past the top of
// the address space, low-vector protection and illegal codes; then random
// phases under several region and protection settings mix write/read-back
// traffic with faulting accesses. Reads never touch bytes not yet written.
// ----------------------------------------------------------------------------
module protected_big_endian_memory_tb;
    import pbem_pkg::*;

    localparam int         MEM_BYTES    = 65536;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASE_ITEMS  = 72;
    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam logic [1:0] SIZE_UNKNOWN = 2'd3;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    in_item_t    request = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        busy;
    logic        result_valid;
    out_item_t   result;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int unsigned cycles = 0;

    int unsigned cfg_region  = REGION_SIZE_RESET;
    bit          cfg_protect = PROTECT_RESET;
    bit          written [MEM_BYTES];
    logic [31:0] recent_writes [$];

    protected_big_endian_memory #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    pbem_result_checker #(
        .MEM_BYTES (MEM_BYTES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int unsigned access_len(logic [1:0] size);
        case (size)
            SIZE_BYTE: return 1;
            SIZE_WORD: return 2;
            SIZE_LONG: return 4;
            default:   return 0;
        endcase
    endfunction

    // stimulus side only: decides whether an access would touch memory
    function automatic bit access_permitted(in_item_t it);
        int unsigned len;
        int unsigned limit;
        len   = access_len(it.access_size);
        limit = (cfg_region > MEM_BYTES) ? MEM_BYTES : cfg_region;
        if (len == 0 || it.command == CMD_UNKNOWN)
            return 0;
        if (cfg_protect && it.address < LOW_VECTOR_LIMIT
            && (it.function_code <= USER_FC_MAX || it.command == CMD_FETCH))
            return 0;
        return ({32'd0, it.address} + len <= limit);
    endfunction

    function automatic in_item_t make_access(logic [1:0] cmd, logic [1:0] size,
                                             logic [31:0] addr, logic [31:0] data,
                                             logic [2:0] fc);
        in_item_t it;
        it.command       = cmd;
        it.access_size   = size;
        it.address       = addr;
        it.write_data    = data;
        it.function_code = fc;
        return it;
    endfunction

    function automatic in_item_t random_access();
        in_item_t    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.command = CMD_READ;
        else if (pick < 75)
            it.command = CMD_WRITE;
        else if (pick < 94)
            it.command = CMD_FETCH;
        else
            it.command = CMD_UNKNOWN;
        if ($urandom_range(0, 19) == 0)
            it.access_size = SIZE_UNKNOWN;
        else
            it.access_size = 2'($urandom_range(SIZE_BYTE, SIZE_LONG));
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                if (recent_writes.size() != 0)
                    it.address = recent_writes[$urandom_range(0, recent_writes.size() - 1)]
                                 + $urandom_range(0, 3);
                else
                    it.address = $urandom_range(0, MEM_BYTES - 1);
            4:       it.address = $urandom_range(0, LOW_VECTOR_LIMIT + 64);
            5:       it.address = cfg_region + $urandom_range(0, 8) - 6;
            6:       it.address = 32'hFFFF_FFFF - $urandom_range(0, 5);
            7:       it.address = $urandom;
            default:
                if (cfg_region != 0)
                    it.address = $urandom_range(0, cfg_region - 1);
                else
                    it.address = $urandom;
        endcase
        it.write_data    = $urandom;
        it.function_code = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic idx, input int unsigned value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PROTECT)
            cfg_protect = value[0];
        else
            cfg_region = value[16:0];
    endtask

    task automatic issue_access(input in_item_t it);
        int unsigned len;
        bit          covered;
        len = access_len(it.access_size);
        // a permitted read of unwritten bytes becomes a write of them
        if (access_permitted(it) && it.command != CMD_WRITE)
        begin
            covered = 1;
            for (int i = 0; i < len; i++)
                if (!written[it.address + i])
                    covered = 0;
            if (!covered)
                it.command = CMD_WRITE;
        end
        if (access_permitted(it) && it.command == CMD_WRITE)
        begin
            for (int i = 0; i < len; i++)
                written[it.address + i] = 1'b1;
            recent_writes.push_back(it.address);
            if (recent_writes.size() > 32)
                void'(recent_writes.pop_front());
        end
        start   <= 1'b1;
        request <= it;
        do @(posedge clk); while (busy);
    endtask

    task automatic run_phase(input int unsigned region, input bit protect, input bit idling);
        cfg_write(REG_REGION_SIZE, region);
        cfg_write(REG_PROTECT, protect);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            issue_access(random_access());
            if (idling && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // edges of the region, wrap and illegal codes, protection off
        cfg_write(REG_REGION_SIZE, MEM_BYTES);
        cfg_write(REG_PROTECT, 0);
        issue_access(make_access(CMD_WRITE, SIZE_LONG, 32'h0, 32'hFFFF_FFFF, 3'd0));
        issue_access(make_access(CMD_READ,  SIZE_BYTE, 32'h0, 32'h0, 3'd0));
        issue_access(make_access(CMD_READ,  SIZE_LONG, 32'h0, 32'h0, 3'd7));
        issue_access(make_access(CMD_WRITE, SIZE_WORD, 32'hFFFE, 32'h0000_A55A, 3'd3));
        issue_access(make_access(CMD_READ,  SIZE_WORD, 32'hFFFE, 32'h0, 3'd1));
        issue_access(make_access(CMD_FETCH, SIZE_BYTE, 32'hFFFF, 32'h0, 3'd7));
        issue_access(make_access(CMD_READ,  SIZE_LONG, 32'hFFFE, 32'h0, 3'd5));
        issue_access(make_access(CMD_WRITE, SIZE_LONG, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 3'd5));
        issue_access(make_access(CMD_READ,  SIZE_BYTE, 32'hFFFF_FFFF, 32'h0, 3'd6));
        issue_access(make_access(CMD_UNKNOWN, SIZE_BYTE, 32'h0, 32'h0, 3'd5));
        issue_access(make_access(CMD_READ,  SIZE_UNKNOWN, 32'h0, 32'h0, 3'd5));
        issue_access(make_access(CMD_WRITE, SIZE_LONG, 32'h3FE, 32'h1234_5678, 3'd5));
        issue_access(make_access(CMD_FETCH, SIZE_LONG, 32'h3FE, 32'h0, 3'd6));

        // low-vector protection on
        cfg_write(REG_PROTECT, 1);
        issue_access(make_access(CMD_READ,  SIZE_LONG, 32'h0, 32'h0, 3'd2));
        issue_access(make_access(CMD_READ,  SIZE_LONG, 32'h0, 32'h0, 3'd3));
        issue_access(make_access(CMD_FETCH, SIZE_WORD, 32'h3FE, 32'h0, 3'd7));
        issue_access(make_access(CMD_FETCH, SIZE_WORD, 32'h400, 32'h0, 3'd7));
        issue_access(make_access(CMD_WRITE, SIZE_BYTE, 32'h3FF, 32'h0000_00EE, 3'd0));
        issue_access(make_access(CMD_READ,  SIZE_BYTE, 32'h3FF, 32'h0, 3'd4));
        issue_access(make_access(CMD_READ,  SIZE_WORD, 32'h400, 32'h0, 3'd0));

        // empty region
        cfg_write(REG_REGION_SIZE, 0);
        issue_access(make_access(CMD_READ,  SIZE_BYTE, 32'h0, 32'h0, 3'd7));
        issue_access(make_access(CMD_WRITE, SIZE_BYTE, 32'h400, 32'h0000_0011, 3'd5));

        run_phase(MEM_BYTES, 1, 1);
        run_phase(MEM_BYTES, 0, 1);
        run_phase(LOW_VECTOR_LIMIT, 1, 1);
        run_phase(0, 0, 1);
        run_phase($urandom_range(LOW_VECTOR_LIMIT + 1, MEM_BYTES - 1), 1, 1);
        run_phase(MEM_BYTES - 1, 0, 1);
        run_phase(1, 1, 1);
        run_phase($urandom_range(1, MEM_BYTES - 1), 0, 1);
        run_phase(MEM_BYTES, 1, 0);

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
